### rtl/core/j1939rx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package j1939rx_pkg;

	// buffer geometry
	localparam int MAX_PACKETS = 6;
	localparam int BYTES_PER_PKT = 7;
	localparam int MAX_BYTES = MAX_PACKETS * BYTES_PER_PKT;
	localparam int LEN_W = 6;
	localparam int IDX_W = $clog2(MAX_PACKETS);
	localparam int CNT_W = $clog2(MAX_PACKETS + 1);
	localparam int TOT_W = $clog2(MAX_PACKETS + 2);
	localparam int CI_W = 3;
	localparam int STORE_W = 56;

	// input actions
	localparam logic [1:0] ACT_CM = 2'd0;
	localparam logic [1:0] ACT_DATA = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	// connection management control bytes
	localparam logic [7:0] CM_RTS = 8'd16;
	localparam logic [7:0] CM_CTS = 8'd17;
	localparam logic [7:0] CM_ACK = 8'd19;
	localparam logic [7:0] CM_BAM = 8'd32;
	localparam logic [7:0] CM_ABORT = 8'd255;

	// result kinds
	typedef enum logic [1:0] {
		KIND_CTS = 2'd0,
		KIND_ACK = 2'd1,
		KIND_CHUNK = 2'd2
	} kind_t;

	// session states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_ACQ = 2'd1,
		ST_READY = 2'd2
	} st_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] source_address;
		logic [7:0] dest_address;
		logic [31:0] data_low;
		logic [31:0] data_high;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] peer_address;
		logic [31:0] word_low;
		logic [31:0] word_high;
		logic [CI_W-1:0] chunk_index;
		logic [LEN_W-1:0] message_length;
		logic last;
	} out_item_t;

	// what the emitter sends for one processed beat
	typedef struct packed {
		logic has_hdr;
		kind_t hdr_kind;
		logic [CNT_W-1:0] hdr_seq;
		logic [CNT_W-1:0] n_chunks;
	} job_t;

	// session context the emitter reads while it drains
	typedef struct packed {
		logic [7:0] peer;
		logic [LEN_W-1:0] length;
		logic [7:0] pgn_spec;
		logic [7:0] pgn_fmt;
		logic [STORE_W-1:0] chunk;
	} ctx_t;

	// number of 7-byte packets that cover a length
	function automatic logic [CNT_W-1:0] pkt_count(input logic [LEN_W-1:0] len);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < MAX_PACKETS; i++) begin
			if (len > LEN_W'(i * BYTES_PER_PKT))
				n = n + CNT_W'(1);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

### rtl/core/j1939rx_emit.sv
`timescale 1ns / 1ps
`default_nettype none
module j1939rx_emit
	import j1939rx_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	input wire job_t job,
	output logic job_ready,
	input wire ctx_t ctx,
	output logic [IDX_W-1:0] chunk_sel,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output out_item_t rsp
);

	logic busy_q;
	logic [TOT_W-1:0] idx_q;
	job_t job_q;

	logic [TOT_W-1:0] last_idx;
	logic [TOT_W-1:0] chunk_pos;
	logic is_last;
	logic hdr_beat;

	assign last_idx = TOT_W'(job_q.has_hdr) + TOT_W'(job_q.n_chunks) - TOT_W'(1);
	assign is_last = (idx_q == last_idx);
	assign hdr_beat = job_q.has_hdr && (idx_q == '0);
	assign chunk_pos = idx_q - TOT_W'(job_q.has_hdr);
	assign chunk_sel = chunk_pos[IDX_W-1:0];

	assign job_ready = !busy_q || (rsp_ready && is_last);
	assign rsp_valid = busy_q;

	// beat counter over header and chunks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (job_ready && job_valid) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (busy_q && rsp_ready) begin
			if (is_last)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + TOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid)
			job_q <= job;
	end

	// result payload
	always_comb begin
		rsp.peer_address = ctx.peer;
		rsp.message_length = ctx.length;
		rsp.last = is_last;
		if (hdr_beat) begin
			rsp.kind = job_q.hdr_kind;
			rsp.chunk_index = '0;
			rsp.word_high = {8'h00, ctx.pgn_fmt, ctx.pgn_spec, 8'hFF};
			if (job_q.hdr_kind == KIND_ACK)
				rsp.word_low = {8'(job_q.n_chunks), 10'd0, ctx.length, CM_ACK};
			else
				rsp.word_low = {8'hFF, 8'(job_q.hdr_seq), 8'h01, CM_CTS};
		end else begin
			rsp.kind = KIND_CHUNK;
			rsp.chunk_index = CI_W'(chunk_pos);
			rsp.word_low = ctx.chunk[31:0];
			rsp.word_high = {8'h00, ctx.chunk[55:32]};
		end
	end

	// a busy emitter always has at least one beat to send
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (job_q.has_hdr || job_q.n_chunks != '0))
		else $error("emitter busy with an empty job");

	// the beat index never runs past the final beat
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= last_idx)
		else $error("beat index beyond last beat");

	// a header beat only comes first
	a_chunk_after_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && rsp.kind != KIND_CHUNK) |-> idx_q == '0)
		else $error("header beat not at start of job");

endmodule
`default_nettype wire

### rtl/core/j1939_tp_receive_reassembler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// J1939 transport protocol receive reassembler.
// req channel (valid/ready): one received transport frame or a buffer release
// per beat. rsp channel (valid/ready): CTS frames, end-of-message ACK frames and
// message chunks, one per beat, with last set on the final beat of a frame.
// cfg_we/cfg_data write own_address; write it only while the block is idle.
// A frame is registered on acceptance; when it is consumed from the input
// register, the session state, packet flags and payload store update and the
// emitter registers its job and presents its first result. The emitter drains
// one result per cycle while rsp_ready is high; a frame that produces results
// holds processing of the next frame until its last result is taken, and a
// frame produces at most seven (ACK plus six chunks). Frames that produce
// nothing sustain one per cycle while the emitter is idle. req_ready stays
// high while the input register is empty or its frame is being processed, so
// the next frame is taken while results still wait. If rsp_ready is held low
// the emitter holds its beat and the input register fills, after which
// req_ready drops. Reset clears the session to idle, own_address, packet flags
// and the payload store to zero; the block accepts frames once reset is released.
module j1939_tp_receive_reassembler_unit
	import j1939rx_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_data,
	input wire logic req_valid,
	output logic req_ready,
	input wire in_item_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output out_item_t rsp
);

	logic [7:0] own_q;
	logic s1_valid_q;
	in_item_t req_s1;

	st_t st_q, st_d;
	logic [7:0] peer_q, peer_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [7:0] spec_q, spec_d;
	logic [7:0] fmt_q, fmt_d;
	logic hs_q, hs_d;
	logic [MAX_PACKETS-1:0] seen_q, seen_d;
	logic [STORE_W-1:0] store_q [MAX_PACKETS];

	logic store_we;
	logic [IDX_W-1:0] store_idx;
	logic [STORE_W-1:0] store_data;

	logic job_valid, job_ready, consume;
	job_t job;
	ctx_t ctx;
	logic [IDX_W-1:0] chunk_sel;

	assign consume = s1_valid_q && job_ready;
	assign req_ready = !s1_valid_q || job_ready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			own_q <= '0;
		else if (cfg_we)
			own_q <= cfg_data;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (req_valid && req_ready)
			s1_valid_q <= 1'b1;
		else if (consume)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			req_s1 <= req;
	end

	// frame processing
	always_comb begin
		logic [7:0] ctl, b1, b2;
		logic [7:0] seq_m1;
		logic in_range, missing;
		logic [CNT_W-1:0] cnt, miss;
		logic [LEN_W-1:0] prod;

		st_d = st_q;
		peer_d = peer_q;
		len_d = len_q;
		spec_d = spec_q;
		fmt_d = fmt_q;
		hs_d = hs_q;
		seen_d = seen_q;
		store_we = 1'b0;
		job_valid = 1'b0;
		job = '{has_hdr: 1'b0, hdr_kind: KIND_CTS, hdr_seq: '0, n_chunks: '0};

		ctl = req_s1.data_low[7:0];
		b1 = req_s1.data_low[15:8];
		b2 = req_s1.data_low[23:16];
		seq_m1 = ctl - 8'd1;
		in_range = (ctl >= 8'd1) && (ctl <= 8'(MAX_PACKETS));
		store_idx = seq_m1[IDX_W-1:0];
		store_data = {req_s1.data_high, req_s1.data_low[31:8]};
		prod = (LEN_W'(ctl[CNT_W-1:0]) << 3) - LEN_W'(ctl[CNT_W-1:0]);
		cnt = pkt_count(len_q);
		missing = 1'b0;
		miss = '0;

		case (req_s1.action)
			ACT_CM: begin
				if (ctl == CM_ACK || ctl == CM_ABORT) begin
					st_d = ST_IDLE;
				end else if ((ctl == CM_RTS && req_s1.dest_address == own_q) || ctl == CM_BAM) begin
					if (st_q == ST_IDLE) begin
						st_d = ST_ACQ;
						hs_d = (ctl == CM_RTS);
						peer_d = req_s1.source_address;
						len_d = (b2 != 8'd0 || b1 >= 8'(MAX_BYTES)) ? LEN_W'(MAX_BYTES)
							: b1[LEN_W-1:0];
						spec_d = req_s1.data_high[15:8];
						fmt_d = req_s1.data_high[23:16];
						seen_d = '0;
						if (ctl == CM_RTS) begin
							job_valid = 1'b1;
							job.has_hdr = 1'b1;
							job.hdr_kind = KIND_CTS;
							job.hdr_seq = CNT_W'(1);
						end
					end
				end
			end
			ACT_DATA: begin
				if (st_q == ST_ACQ && req_s1.source_address == peer_q) begin
					store_we = in_range;
					for (int i = 0; i < MAX_PACKETS; i++) begin
						if (in_range && store_idx == IDX_W'(i))
							seen_d[i] = 1'b1;
					end
					if (hs_q) begin
						// first missing packet among those the length needs
						for (int i = MAX_PACKETS - 1; i >= 0; i--) begin
							if (CNT_W'(i) < cnt && !seen_d[i]) begin
								missing = 1'b1;
								miss = CNT_W'(i);
							end
						end
						job_valid = 1'b1;
						job.has_hdr = 1'b1;
						if (missing) begin
							job.hdr_kind = KIND_CTS;
							job.hdr_seq = miss + CNT_W'(1);
						end else begin
							job.hdr_kind = KIND_ACK;
							job.n_chunks = cnt;
							st_d = ST_READY;
						end
					end else if (in_range && prod >= len_q) begin
						job_valid = (cnt != '0);
						job.n_chunks = cnt;
						st_d = ST_READY;
					end
				end
			end
			ACT_RELEASE: begin
				if (st_q == ST_READY)
					st_d = ST_IDLE;
			end
			default: begin
			end
		endcase
	end

	// session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			peer_q <= '0;
			len_q <= '0;
			spec_q <= '0;
			fmt_q <= '0;
			hs_q <= 1'b0;
			seen_q <= '0;
		end else if (consume) begin
			st_q <= st_d;
			peer_q <= peer_d;
			len_q <= len_d;
			spec_q <= spec_d;
			fmt_q <= fmt_d;
			hs_q <= hs_d;
			seen_q <= seen_d;
		end
	end

	// payload store, zero after reset since chunks of lost packets read it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PACKETS; i++)
				store_q[i] <= '0;
		end else if (consume && store_we) begin
			store_q[store_idx] <= store_data;
		end
	end

	assign ctx = '{peer: peer_q, length: len_q, pgn_spec: spec_q, pgn_fmt: fmt_q,
		chunk: store_q[chunk_sel]};

	j1939rx_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(consume && job_valid),
		.job(job),
		.job_ready(job_ready),
		.ctx(ctx),
		.chunk_sel(chunk_sel),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// chunks and the ACK go out only once the message is complete
	a_chunk_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.kind != KIND_CTS) |-> st_q == ST_READY)
		else $error("chunk or ACK outside ready state");

	// a CTS belongs to an open handshake session
	a_cts_session: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.kind == KIND_CTS) |-> (st_q == ST_ACQ && hs_q))
		else $error("CTS without handshake session");

	// broadcast sessions never produce an ACK
	a_ack_hs: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.kind == KIND_ACK) |-> hs_q)
		else $error("ACK in broadcast session");

endmodule
`default_nettype wire

### tb/sv/tb_reasm_pkg.sv
`timescale 1ns / 1ps
package tb_reasm_pkg;
	import j1939rx_pkg::*;

	// predicts the reassembler beat by beat and checks what it sends
	class reasm_scoreboard;
		logic [7:0] own_addr;
		st_t sess_state;
		logic [7:0] sess_peer;
		logic [LEN_W-1:0] msg_len;
		logic [7:0] pgn_spec;
		logic [7:0] pgn_fmt;
		bit handshake;
		bit seen [MAX_PACKETS];
		logic [STORE_W-1:0] store [MAX_PACKETS];
		out_item_t beat_q [$];
		int errors;
		int checked;
		int messages;

		function new();
			own_addr = '0;
			sess_state = ST_IDLE;
			sess_peer = '0;
			msg_len = '0;
			pgn_spec = '0;
			pgn_fmt = '0;
			handshake = 1'b0;
			errors = 0;
			checked = 0;
			messages = 0;
			for (int i = 0; i < MAX_PACKETS; i++) begin
				seen[i] = 1'b0;
				store[i] = '0;
			end
		endfunction

		function void set_own_address(logic [7:0] a);
			own_addr = a;
		endfunction

		// packets that cover the accepted length
		function int packets_needed();
			int n;
			n = (int'(msg_len) + 6) / BYTES_PER_PKT;
			return (n > MAX_PACKETS) ? MAX_PACKETS : n;
		endfunction

		function logic [31:0] pgn_word();
			return {8'h00, pgn_fmt, pgn_spec, 8'hFF};
		endfunction

		function logic [31:0] cts_word(int seq);
			return {8'hFF, 8'(seq), 8'h01, CM_CTS};
		endfunction

		function void push_beat(kind_t k, logic [31:0] wl, logic [31:0] wh, int idx);
			out_item_t b;
			b.kind = k;
			b.peer_address = sess_peer;
			b.word_low = wl;
			b.word_high = wh;
			b.chunk_index = CI_W'(idx);
			b.message_length = msg_len;
			b.last = 1'b0;
			beat_q.push_back(b);
		endfunction

		// message complete: one chunk per covering packet, stale or not
		function void push_chunks();
			for (int i = 0; i < packets_needed(); i++)
				push_beat(KIND_CHUNK, store[i][31:0], {8'h00, store[i][55:32]}, i);
			messages++;
			sess_state = ST_READY;
		endfunction

		function void open_session(in_item_t it, bit hs);
			logic [7:0] b1;
			logic [7:0] b2;
			b1 = it.data_low[15:8];
			b2 = it.data_low[23:16];
			sess_state = ST_ACQ;
			handshake = hs;
			sess_peer = it.source_address;
			msg_len = (b2 != 8'h00 || b1 >= MAX_BYTES) ? LEN_W'(MAX_BYTES) : b1[LEN_W-1:0];
			pgn_spec = it.data_high[15:8];
			pgn_fmt = it.data_high[23:16];
			for (int i = 0; i < MAX_PACKETS; i++)
				seen[i] = 1'b0;
		endfunction

		function void note_input(in_item_t it);
			int first_beat;
			int seq;
			int cnt;
			int miss;
			logic [7:0] ctl;
			first_beat = beat_q.size();
			ctl = it.data_low[7:0];
			case (it.action)
				ACT_CM: begin
					if (ctl == CM_ACK || ctl == CM_ABORT) begin
						sess_state = ST_IDLE;
					end else if (ctl == CM_RTS) begin
						if (sess_state == ST_IDLE && it.dest_address == own_addr) begin
							open_session(it, 1'b1);
							push_beat(KIND_CTS, cts_word(1), pgn_word(), 0);
						end
					end else if (ctl == CM_BAM && sess_state == ST_IDLE) begin
						open_session(it, 1'b0);
					end
				end
				ACT_DATA: begin
					if (sess_state == ST_ACQ && it.source_address == sess_peer) begin
						seq = int'(ctl);
						if (seq >= 1 && seq <= MAX_PACKETS) begin
							seen[seq-1] = 1'b1;
							store[seq-1] = {it.data_high, it.data_low[31:8]};
						end
						if (handshake) begin
							// ask for the first hole, or acknowledge and deliver
							cnt = packets_needed();
							miss = cnt;
							for (int i = cnt - 1; i >= 0; i--)
								if (!seen[i])
									miss = i;
							if (miss < cnt) begin
								push_beat(KIND_CTS, cts_word(miss + 1), pgn_word(), 0);
							end else begin
								push_beat(KIND_ACK, {8'(cnt), 10'b0, msg_len, CM_ACK},
									pgn_word(), 0);
								push_chunks();
							end
						end else if (seq >= 1 && seq <= MAX_PACKETS &&
								seq * BYTES_PER_PKT >= int'(msg_len)) begin
							push_chunks();
						end
					end
				end
				ACT_RELEASE: begin
					if (sess_state == ST_READY)
						sess_state = ST_IDLE;
				end
				default: ;
			endcase
			if (beat_q.size() > first_beat)
				beat_q[beat_q.size()-1].last = 1'b1;
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("mismatch: %s got %0h expected %0h", what, got, want);
		endtask

		task check_result(out_item_t r);
			out_item_t e;
			checked++;
			if (beat_q.size() == 0) begin
				report("beat with nothing pending, kind", r.kind, 0);
				return;
			end
			e = beat_q.pop_front();
			if (r.kind != e.kind)
				report("kind", r.kind, e.kind);
			if (r.peer_address != e.peer_address)
				report("peer_address", r.peer_address, e.peer_address);
			if (r.word_low != e.word_low)
				report("word_low", r.word_low, e.word_low);
			if (r.word_high != e.word_high)
				report("word_high", r.word_high, e.word_high);
			if (r.chunk_index != e.chunk_index)
				report("chunk_index", r.chunk_index, e.chunk_index);
			if (r.message_length != e.message_length)
				report("message_length", r.message_length, e.message_length);
			if (r.last != e.last)
				report("last", r.last, e.last);
		endtask
	endclass

endpackage

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import j1939rx_pkg::*;
	import tb_reasm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_FRAMES = 88;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_data = 8'h00;
	logic req_valid = 1'b0;
	logic req_ready;
	in_item_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	out_item_t rsp;

	reasm_scoreboard sb;
	int frames_sent = 0;
	int settings_used = 0;
	int cycle_count = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	bit rx_hold_req = 1'b0;
	bit line_dirty = 1'b0;

	j1939_tp_receive_reassembler_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// gap before a beat, with occasional stretches of back-to-back traffic
	function automatic int draw_wait(inout bit burst);
		if ($urandom_range(0, 15) == 0)
			burst = !burst;
		return burst ? 0 : $urandom_range(0, 15);
	endfunction

	// connection management frame: control byte, length in bytes 1..2, pgn in bytes 5..6
	function automatic in_item_t cm_frame(logic [7:0] ctl, logic [7:0] src, logic [7:0] dst,
			logic [15:0] len, logic [7:0] pspec, logic [7:0] pfmt);
		in_item_t it;
		it.action = ACT_CM;
		it.source_address = src;
		it.dest_address = dst;
		it.data_low = {8'($urandom), len[15:8], len[7:0], ctl};
		it.data_high = {8'($urandom), pfmt, pspec, 8'($urandom)};
		return it;
	endfunction

	function automatic in_item_t data_frame(logic [7:0] src, logic [7:0] seq);
		in_item_t it;
		it.action = ACT_DATA;
		it.source_address = src;
		it.dest_address = 8'($urandom);
		it.data_low = {24'($urandom), seq};
		it.data_high = $urandom;
		return it;
	endfunction

	function automatic in_item_t release_frame();
		in_item_t it;
		it.action = ACT_RELEASE;
		it.source_address = 8'($urandom);
		it.dest_address = 8'($urandom);
		it.data_low = $urandom;
		it.data_high = $urandom;
		return it;
	endfunction

	// offer one beat and hold it until taken
	task automatic send_frame(in_item_t it);
		int gap;
		gap = draw_wait(tx_burst);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (!req_ready);
		frames_sent++;
	endtask

	// stop offering and let every pending result come out
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.beat_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_own(logic [7:0] a);
		cfg_we <= 1'b1;
		cfg_data <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_own_address(a);
		settings_used++;
	endtask

	// one well-formed session with random content and a few broken frames mixed in
	task automatic run_session(bit hs, logic [15:0] len);
		logic [7:0] src;
		logic [7:0] pspec;
		logic [7:0] pfmt;
		int cnt;
		int j;
		int tmp;
		int order [$];
		src = 8'($urandom);
		pspec = 8'($urandom);
		pfmt = 8'($urandom);
		cnt = (len[15:8] != 8'h00 || len[7:0] >= MAX_BYTES) ? MAX_PACKETS :
			(int'(len[7:0]) + 6) / BYTES_PER_PKT;
		if (line_dirty)
			send_frame(cm_frame(CM_ABORT, 8'($urandom), 8'($urandom), 16'($urandom), 8'h00,
				8'h00));
		send_frame(cm_frame(hs ? CM_RTS : CM_BAM, src, hs ? sb.own_addr : 8'($urandom), len,
			pspec, pfmt));
		for (int i = 1; i <= cnt; i++)
			order.push_back(i);
		// a zero-length broadcast still needs one in-range packet to finish
		if (cnt == 0)
			order.push_back($urandom_range(1, MAX_PACKETS));
		if (hs || $urandom_range(0, 3) == 0) begin
			for (int i = order.size() - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
		end
		foreach (order[k]) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 2))
					0: send_frame(data_frame(src + 8'($urandom_range(1, 255)), 8'(order[k])));
					1: send_frame(data_frame(src,
						($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom_range(7, 255))));
					default: send_frame(data_frame(src, 8'($urandom_range(1, MAX_PACKETS))));
				endcase
			end
			send_frame(data_frame(src, 8'(order[k])));
		end
		if ($urandom_range(0, 7) != 0)
			send_frame(release_frame());
		else
			send_frame(cm_frame(CM_ABORT, src, 8'($urandom), 16'($urandom), 8'h00, 8'h00));
		line_dirty = 1'b0;
	endtask

	// arbitrary frame, control bytes favored
	task automatic send_noise();
		in_item_t it;
		it.action = 2'($urandom_range(0, 3));
		it.source_address = 8'($urandom);
		it.dest_address = 8'($urandom);
		it.data_low = $urandom;
		it.data_high = $urandom;
		if (it.action == ACT_CM && $urandom_range(0, 1) != 0) begin
			case ($urandom_range(0, 4))
				0: it.data_low[7:0] = CM_RTS;
				1: it.data_low[7:0] = CM_CTS;
				2: it.data_low[7:0] = CM_ACK;
				3: it.data_low[7:0] = CM_BAM;
				default: it.data_low[7:0] = CM_ABORT;
			endcase
		end
		send_frame(it);
		line_dirty = 1'b1;
	endtask

	// watch both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_input(req);
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp);
		end
	end

	// receiver: random back-pressure, one long hold on request
	initial begin
		int wait_cycles;
		forever begin
			if (rx_hold_req) begin
				wait_cycles = RX_HOLD_CYCLES;
				rx_hold_req = 1'b0;
			end else begin
				wait_cycles = draw_wait(rx_burst);
			end
			if (wait_cycles > 0) begin
				rsp_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		in_item_t it;
		logic [15:0] len;
		int target;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: handshake with a hole, busy rts, foreign and out-of-range data
		write_own(8'hFF);
		send_frame(cm_frame(CM_RTS, 8'h00, 8'hFF, 16'd10, 8'h00, 8'hFF));
		send_frame(cm_frame(CM_RTS, 8'h55, 8'hFF, 16'd20, 8'h12, 8'h34));
		send_frame(data_frame(8'h01, 8'd1));
		send_frame(data_frame(8'h00, 8'd0));
		send_frame(data_frame(8'h00, 8'd2));
		send_frame(data_frame(8'h00, 8'd1));
		send_frame(data_frame(8'h00, 8'd1));
		send_frame(release_frame());
		send_frame(release_frame());
		// broadcast clamped by a nonzero high length byte, payload extremes
		send_frame(cm_frame(CM_BAM, 8'hFF, 8'hFF, 16'h0105, 8'hFF, 8'h00));
		send_frame(data_frame(8'hFF, 8'd7));
		for (int s = 1; s <= MAX_PACKETS; s++) begin
			it = data_frame(8'hFF, 8'(s));
			if (s == 1) begin
				it.data_low[31:8] = '0;
				it.data_high = '0;
			end else if (s == MAX_PACKETS) begin
				it.data_low[31:8] = '1;
				it.data_high = '1;
			end
			send_frame(it);
		end
		send_frame(cm_frame(CM_ABORT, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00));
		// rts to another node, then zero length handshake
		send_frame(cm_frame(CM_RTS, 8'h10, 8'hFE, 16'd7, 8'h01, 8'h02));
		send_frame(cm_frame(CM_RTS, 8'h22, 8'hFF, 16'd0, 8'h03, 8'h04));
		send_frame(data_frame(8'h22, 8'd3));
		send_frame(cm_frame(CM_ACK, 8'h22, 8'hFF, 16'd0, 8'h00, 8'h00));
		// zero length broadcast, received cts, unknown control, undefined action
		send_frame(cm_frame(CM_BAM, 8'h33, 8'hFF, 16'd0, 8'h05, 8'h06));
		send_frame(data_frame(8'h33, 8'd0));
		send_frame(data_frame(8'h33, 8'd1));
		send_frame(cm_frame(CM_CTS, 8'h33, 8'hFF, 16'd1, 8'h00, 8'h00));
		send_frame(cm_frame(8'h42, 8'h33, 8'hFF, 16'd1, 8'h00, 8'h00));
		it = release_frame();
		it.action = 2'b11;
		send_frame(it);
		send_frame(release_frame());
		drain();

		// random phases under different own addresses
		target = frames_sent;
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: write_own(8'h00);
				3: write_own(8'hFF);
				default: write_own(8'($urandom));
			endcase
			if (p == 1) begin
				// receiver stalls while a full message is pushed in
				rx_hold_req = 1'b1;
				run_session(1'b1, 16'd42);
			end
			target += RANDOM_FRAMES / 4;
			while (frames_sent < target) begin
				case ($urandom_range(0, 7))
					0: len = 16'($urandom_range(43, 65535));
					1: len = 16'd0;
					default: len = 16'($urandom_range(1, MAX_BYTES));
				endcase
				if ($urandom_range(0, 9) < 8)
					run_session($urandom_range(0, 3) != 0, len);
				else
					send_noise();
				if ($urandom_range(0, 9) == 0)
					drain();
			end
			drain();
		end

		if (sb.beat_q.size() != 0)
			sb.report("results never delivered", sb.beat_q.size(), 0);
		$display("covered %0d frames under %0d own-address settings, %0d result beats checked",
			frames_sent, settings_used, sb.checked);
		$display("%0d messages reassembled, %0d mismatches", sb.messages, sb.errors);
		if (sb.errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
